// ----- rtl/core/cma_pkg.sv -----
// Shared types, constants and helpers for the confusion matrix accumulator.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package cma_pkg;

  // Matrix geometry and field widths.
  localparam int MAX_CLASSES = 16;
  localparam int SCORE_BITS  = 16;
  localparam int COUNT_BITS  = 32;
  localparam int CFG_BITS    = 5;
  localparam int IDX_BITS    = $clog2(MAX_CLASSES);
  localparam int ADDR_BITS   = 2 * IDX_BITS;
  localparam int DEPTH       = MAX_CLASSES * MAX_CLASSES;
  localparam int N_BITS      = $clog2(MAX_CLASSES + 1);
  localparam int KIND_BITS   = 2;

  // Input transaction kinds. The remaining code is ignored by the block.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_PAIR  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // Request handed from the sample tracker to the count store.
  typedef struct packed {
    logic                 valid;
    logic                 is_read;
    logic                 oob;
    logic                 counted;
    logic [ADDR_BITS-1:0] addr;
    logic [IDX_BITS-1:0]  pred_idx;
    logic [IDX_BITS-1:0]  exp_idx;
  } req_t;

  // Class count in force: the register value clamped to [2, MAX_CLASSES].
  function automatic logic [N_BITS-1:0] classes_in_force(input logic [CFG_BITS-1:0] v);
    logic [N_BITS-1:0] n;
    if (int'(v) < 2) begin
      n = N_BITS'(2);
    end else if (int'(v) > MAX_CLASSES) begin
      n = N_BITS'(MAX_CLASSES);
    end else begin
      n = N_BITS'(v);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cma_sample_unit.sv -----
// Sample tracker: running argmax of predicted and expected scores per sample.
// Decodes input transactions into store requests. Depends on cma_pkg.
`default_nettype none

module cma_sample_unit import cma_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [KIND_BITS-1:0]         kind,
  input  logic signed [SCORE_BITS-1:0] predicted_score,
  input  logic signed [SCORE_BITS-1:0] expected_score,
  input  logic [IDX_BITS-1:0]          read_row,
  input  logic [IDX_BITS-1:0]          read_col,
  input  logic [N_BITS-1:0]            n_classes,
  input  logic                         restart,
  output req_t                         req,
  output logic                         clear_req
);

  logic [IDX_BITS-1:0]          pos_r, pos_nxt;
  logic signed [SCORE_BITS-1:0] best_p_r, best_p_nxt;
  logic signed [SCORE_BITS-1:0] best_e_r, best_e_nxt;
  logic [IDX_BITS-1:0]          idx_p_r, idx_p_nxt;
  logic [IDX_BITS-1:0]          idx_e_r, idx_e_nxt;

  logic                         is_pair;
  logic                         is_read;
  logic                         first;
  logic                         last;
  logic                         take_p;
  logic                         take_e;
  logic signed [SCORE_BITS-1:0] new_p;
  logic signed [SCORE_BITS-1:0] new_e;
  logic [IDX_BITS-1:0]          new_idx_p;
  logic [IDX_BITS-1:0]          new_idx_e;

  assign is_pair = (kind == KIND_PAIR);
  assign is_read = (kind == KIND_READ);

  // Argmax update; the first class is taken unconditionally, ties keep the earlier one.
  assign first     = (pos_r == '0);
  assign take_p    = first || (best_p_r < predicted_score);
  assign take_e    = first || (best_e_r < expected_score);
  assign new_p     = take_p ? predicted_score : best_p_r;
  assign new_e     = take_e ? expected_score : best_e_r;
  assign new_idx_p = take_p ? pos_r : idx_p_r;
  assign new_idx_e = take_e ? pos_r : idx_e_r;
  assign last      = ((N_BITS'(pos_r) + N_BITS'(1)) >= n_classes);

  // Next state of the tracker.
  always_comb begin
    pos_nxt    = pos_r;
    best_p_nxt = best_p_r;
    best_e_nxt = best_e_r;
    idx_p_nxt  = idx_p_r;
    idx_e_nxt  = idx_e_r;
    if (restart || (accept && is_pair && last)) begin
      pos_nxt    = '0;
      best_p_nxt = {1'b1, {(SCORE_BITS-1){1'b0}}};
      best_e_nxt = {1'b1, {(SCORE_BITS-1){1'b0}}};
      idx_p_nxt  = '0;
      idx_e_nxt  = '0;
    end else if (accept && is_pair) begin
      pos_nxt    = pos_r + IDX_BITS'(1);
      best_p_nxt = new_p;
      best_e_nxt = new_e;
      idx_p_nxt  = new_idx_p;
      idx_e_nxt  = new_idx_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      best_p_r <= {1'b1, {(SCORE_BITS-1){1'b0}}};
      best_e_r <= {1'b1, {(SCORE_BITS-1){1'b0}}};
      idx_p_r  <= '0;
      idx_e_r  <= '0;
    end else begin
      pos_r    <= pos_nxt;
      best_p_r <= best_p_nxt;
      best_e_r <= best_e_nxt;
      idx_p_r  <= idx_p_nxt;
      idx_e_r  <= idx_e_nxt;
    end
  end

  // Request toward the store: end of sample or cell read.
  always_comb begin
    req.valid    = accept && ((is_pair && last) || is_read);
    req.is_read  = is_read;
    req.oob      = (N_BITS'(read_row) >= n_classes) || (N_BITS'(read_col) >= n_classes);
    req.counted  = !new_e[SCORE_BITS-1];
    req.pred_idx = new_idx_p;
    req.exp_idx  = new_idx_e;
    req.addr     = is_read ? {read_row, read_col} : {new_idx_e, new_idx_p};
  end

  assign clear_req = accept && (kind == KIND_CLEAR);

endmodule

`default_nettype wire

// ----- rtl/core/cma_count_store.sv -----
// Count store: matrix memory with flash-cleared valid bits, read-modify-write
// stage with write forwarding, and the result register. Depends on cma_pkg.
`default_nettype none

module cma_count_store import cma_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  req_t                  req,
  input  logic                  clear,
  output logic                  req_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_is_read_reply,
  output logic [COUNT_BITS-1:0] out_cell_count,
  output logic [IDX_BITS-1:0]   out_predicted_class,
  output logic [IDX_BITS-1:0]   out_expected_class,
  output logic                  out_sample_counted
);

  logic [COUNT_BITS-1:0] count_mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic [DEPTH-1:0]      vld_r;

  logic                  s2_valid_r;
  req_t                  s2_r;

  logic                  fwd_valid_r;
  logic [ADDR_BITS-1:0]  fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic                  out_valid_r;
  logic                  out_is_read_r;
  logic [COUNT_BITS-1:0] out_count_r;
  logic [IDX_BITS-1:0]   out_pred_r;
  logic [IDX_BITS-1:0]   out_exp_r;
  logic                  out_counted_r;

  logic                  out_free;
  logic                  s2_adv;
  logic                  s2_fire;
  logic [COUNT_BITS-1:0] cur;
  logic                  sat;
  logic [COUNT_BITS-1:0] inc;
  logic                  mem_we;
  logic [COUNT_BITS-1:0] result_count;

  // Stage enables: the result register frees the modify stage, which frees the read.
  assign out_free  = !out_valid_r || out_ready;
  assign s2_adv    = !s2_valid_r || out_free;
  assign s2_fire   = s2_valid_r && out_free;
  assign req_ready = s2_adv;

  // Memory read port, registered, held while the modify stage stalls.
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      rd_data_r <= count_mem[req.addr];
    end
  end

  // Memory write port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem[s2_r.addr] <= inc;
    end
  end

  // Modify stage control and payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_r <= req;
    end
  end

  // Current count: last write forwarded, then memory if the entry was written since clear.
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s2_r.addr)) begin
      cur = fwd_data_r;
    end else if (vld_r[s2_r.addr]) begin
      cur = rd_data_r;
    end else begin
      cur = '0;
    end
  end

  assign sat    = &cur;
  assign inc    = cur + COUNT_BITS'(1);
  assign mem_we = s2_fire && !s2_r.is_read && s2_r.counted && !sat;

  always_comb begin
    if (s2_r.is_read) begin
      result_count = s2_r.oob ? '0 : cur;
    end else begin
      result_count = mem_we ? inc : cur;
    end
  end

  // Valid bits; a clear takes priority over a write in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clear) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[s2_r.addr] <= 1'b1;
    end
  end

  // Last write kept for a read issued on the same edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (clear) begin
      fwd_valid_r <= 1'b0;
    end else if (mem_we) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fwd_addr_r <= s2_r.addr;
      fwd_data_r <= inc;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_is_read_r <= s2_r.is_read;
      out_count_r   <= result_count;
      out_pred_r    <= s2_r.is_read ? '0 : s2_r.pred_idx;
      out_exp_r     <= s2_r.is_read ? '0 : s2_r.exp_idx;
      out_counted_r <= !s2_r.is_read && s2_r.counted;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_is_read_reply   = out_is_read_r;
  assign out_cell_count      = out_count_r;
  assign out_predicted_class = out_pred_r;
  assign out_expected_class  = out_exp_r;
  assign out_sample_counted  = out_counted_r;

`ifndef SYNTHESIS
  // A clear empties the store even when a write lands on the same edge.
  a_clear_wins: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> (vld_r == '0) && !fwd_valid_r)
    else $error("valid bits survived a clear");

  // A write with no clear in its cycle shows in the forwarding path on the next cycle.
  a_fwd_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && !clear) |=> fwd_valid_r && (fwd_addr_r == $past(s2_r.addr))
      && vld_r[$past(s2_r.addr)])
    else $error("forwarding register missed a write");

  // A saturating increment never wraps to zero.
  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (inc != '0))
    else $error("count wrapped");

  // A counted sample reports a nonzero count.
  a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_is_read_r && out_counted_r) |-> (out_count_r != '0))
    else $error("counted sample reported zero");

  // Read replies carry no class indexes.
  a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_is_read_r) |-> (out_pred_r == '0) && (out_exp_r == '0)
      && !out_counted_r)
    else $error("read reply carries sample fields");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/confusion_matrix_accumulator.sv -----
// Confusion matrix accumulator top level: configuration register and channel wiring.
// Instantiates cma_sample_unit and cma_count_store; depends on cma_pkg.
//
// One transaction is accepted per clock cycle as long as the result side keeps up. A sample
// is class_count score-pair transactions; its argmax is tracked as the pairs arrive, and the
// report for the sample, like a read reply, goes through the memory read and then the
// read-modify-write stage before it leaves the result register.
// The counts sit in a 256-entry single-port-write, one-read memory; back-to-back updates of
// the same cell are served by forwarding the last write, so there is no interlock bubble.
// Clear transactions and reset empty the matrix at once through per-entry valid bits, with
// no clearing pass. in_ready drops only when a result is held in the output register and the
// modify stage is also full. A write of cfg_class_count that changes the clamped class count
// clears the matrix and restarts the sample being collected; write it only while idle.
`default_nettype none

module confusion_matrix_accumulator import cma_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [KIND_BITS-1:0]         in_kind,
  input  logic signed [SCORE_BITS-1:0] in_predicted_score,
  input  logic signed [SCORE_BITS-1:0] in_expected_score,
  input  logic [IDX_BITS-1:0]          in_read_row,
  input  logic [IDX_BITS-1:0]          in_read_col,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_is_read_reply,
  output logic [COUNT_BITS-1:0]        out_cell_count,
  output logic [IDX_BITS-1:0]          out_predicted_class,
  output logic [IDX_BITS-1:0]          out_expected_class,
  output logic                         out_sample_counted,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_BITS-1:0]          cfg_class_count
);

  logic [CFG_BITS-1:0] class_count_r;
  logic                cfg_fire;
  logic                restart;
  logic                accept;
  logic                clear_req;
  logic                clear;
  logic                store_ready;
  logic [N_BITS-1:0]   n_classes;
  req_t                req;

  // Configuration register; a new count in force restarts the sample and clears the matrix.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign restart   = cfg_fire &&
                     (classes_in_force(cfg_class_count) != classes_in_force(class_count_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r <= CFG_BITS'(2);
    end else if (cfg_fire) begin
      class_count_r <= cfg_class_count;
    end
  end

  assign n_classes = classes_in_force(class_count_r);

  // Input handshake.
  assign in_ready = store_ready;
  assign accept   = in_valid && in_ready;
  assign clear    = clear_req || restart;

  cma_sample_unit u_sample (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .kind            (in_kind),
    .predicted_score (in_predicted_score),
    .expected_score  (in_expected_score),
    .read_row        (in_read_row),
    .read_col        (in_read_col),
    .n_classes       (n_classes),
    .restart         (restart),
    .req             (req),
    .clear_req       (clear_req)
  );

  cma_count_store u_store (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req                 (req),
    .clear               (clear),
    .req_ready           (store_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_is_read_reply   (out_is_read_reply),
    .out_cell_count      (out_cell_count),
    .out_predicted_class (out_predicted_class),
    .out_expected_class  (out_expected_class),
    .out_sample_counted  (out_sample_counted)
  );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for confusion_matrix_accumulator: a directed table, then random phases
// over several class counts, each result checked against a fixed answer or an in-bench model.
// Depends on cma_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb;
  import cma_pkg::*;

  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned DRAIN_PAD       = 8;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned N_PHASES        = 8;
  localparam logic signed [SCORE_BITS-1:0] SCORE_LO = {1'b1, {(SCORE_BITS-1){1'b0}}};
  localparam logic signed [SCORE_BITS-1:0] SCORE_HI = {1'b0, {(SCORE_BITS-1){1'b1}}};

  typedef enum int unsigned {
    STYLE_ANY, STYLE_HOT, STYLE_TIGHT, STYLE_EDGE, STYLE_NEG
  } score_style_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]         kind;
    logic signed [SCORE_BITS-1:0] pscore;
    logic signed [SCORE_BITS-1:0] escore;
    logic [IDX_BITS-1:0]          row;
    logic [IDX_BITS-1:0]          col;
  } item_t;

  typedef struct packed {
    logic                  is_read;
    logic [COUNT_BITS-1:0] count;
    logic [IDX_BITS-1:0]   pclass;
    logic [IDX_BITS-1:0]   eclass;
    logic                  counted;
  } report_t;

  typedef struct packed {
    item_t   item;
    logic    fixed;
    report_t want;
  } step_row_t;

  localparam report_t NO_REPORT = '0;
  localparam report_t READ_ZERO = '{1'b1, '0, '0, '0, 1'b0};
  localparam report_t FIRST_HIT = '{1'b0, 32'd1, '0, '0, 1'b1};

  // Directed steps at the reset class count of two. Rows with fixed set carry their answer.
  localparam step_row_t DIRECTED_STEPS [22] = '{
    // Reads after reset, in range and past the matrix edge.
    '{'{KIND_READ, 16'sd0, 16'sd0, 4'd0, 4'd0}, 1'b1, READ_ZERO},
    '{'{KIND_READ, 16'sd0, 16'sd0, 4'd15, 4'd15}, 1'b1, READ_ZERO},
    '{'{KIND_READ, 16'sd0, 16'sd0, 4'd1, 4'd15}, 1'b1, READ_ZERO},
    // All-minimum sample: index 0 for both, negative label maximum, not counted.
    '{'{KIND_PAIR, SCORE_LO, SCORE_LO, 4'd0, 4'd0}, 1'b0, NO_REPORT},
    '{'{KIND_PAIR, SCORE_LO, SCORE_LO, 4'd0, 4'd0}, 1'b1, NO_REPORT},
    // Ties at the top value: the first maximum wins.
    '{'{KIND_PAIR, SCORE_HI, 16'sd0, 4'd0, 4'd0}, 1'b0, NO_REPORT},
    '{'{KIND_PAIR, SCORE_HI, 16'sd0, 4'd0, 4'd0}, 1'b1, FIRST_HIT},
    '{'{KIND_PAIR, 16'sd0, -16'sd1, 4'd0, 4'd0}, 1'b0, NO_REPORT},
    '{'{KIND_PAIR, 16'sd1, 16'sd5, 4'd0, 4'd0}, 1'b0, NO_REPORT},
    '{'{KIND_READ, 16'sd0, 16'sd0, 4'd1, 4'd1}, 1'b0, NO_REPORT},
    '{'{KIND_READ, 16'sd0, 16'sd0, 4'd0, 4'd0}, 1'b0, NO_REPORT},
    // Unused kind with every field bit set is ignored.
    '{'{KIND_UNUSED, -16'sd1, -16'sd1, 4'd15, 4'd15}, 1'b0, NO_REPORT},
    // A clear in the middle of a sample keeps the sample going.
    '{'{KIND_PAIR, 16'sd5, 16'sd3, 4'd0, 4'd0}, 1'b0, NO_REPORT},
    '{'{KIND_CLEAR, 16'sd0, 16'sd0, 4'd0, 4'd0}, 1'b0, NO_REPORT},
    '{'{KIND_READ, 16'sd0, 16'sd0, 4'd0, 4'd0}, 1'b1, READ_ZERO},
    '{'{KIND_PAIR, -16'sd1, 16'sd7, 4'd0, 4'd0}, 1'b0, NO_REPORT},
    // Label maximum of -1 leaves the matrix alone.
    '{'{KIND_PAIR, -16'sd1, SCORE_LO, 4'd0, 4'd0}, 1'b0, NO_REPORT},
    '{'{KIND_PAIR, -16'sd2, -16'sd1, 4'd0, 4'd0}, 1'b0, NO_REPORT},
    '{'{KIND_PAIR, SCORE_HI, SCORE_HI, 4'd0, 4'd0}, 1'b0, NO_REPORT},
    '{'{KIND_PAIR, SCORE_HI, SCORE_HI, 4'd0, 4'd0}, 1'b0, NO_REPORT},
    '{'{KIND_READ, 16'sd0, 16'sd0, 4'd1, 4'd0}, 1'b0, NO_REPORT},
    // Leaves a sample half collected across the next register write.
    '{'{KIND_PAIR, 16'sh1234, -16'sd5, 4'd0, 4'd0}, 1'b0, NO_REPORT}
  };

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [KIND_BITS-1:0]         in_kind;
  logic signed [SCORE_BITS-1:0] in_predicted_score;
  logic signed [SCORE_BITS-1:0] in_expected_score;
  logic [IDX_BITS-1:0]          in_read_row;
  logic [IDX_BITS-1:0]          in_read_col;
  logic                         out_valid;
  logic                         out_ready;
  logic                         out_is_read_reply;
  logic [COUNT_BITS-1:0]        out_cell_count;
  logic [IDX_BITS-1:0]          out_predicted_class;
  logic [IDX_BITS-1:0]          out_expected_class;
  logic                         out_sample_counted;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_BITS-1:0]          cfg_class_count;

  // Model of the matrix and of the sample being collected.
  logic [COUNT_BITS-1:0]        cell_counts [DEPTH];
  int unsigned                  sample_pos;
  logic signed [SCORE_BITS-1:0] top_pscore;
  logic signed [SCORE_BITS-1:0] top_escore;
  logic [IDX_BITS-1:0]          top_pclass;
  logic [IDX_BITS-1:0]          top_eclass;
  logic [CFG_BITS-1:0]          class_reg;
  report_t                      pending_reports [$];

  bit          failed;
  bit          calm_in;
  bit          calm_out;
  int unsigned stall_left;
  int unsigned cycles;

  confusion_matrix_accumulator i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_predicted_score (in_predicted_score),
    .in_expected_score  (in_expected_score),
    .in_read_row        (in_read_row),
    .in_read_col        (in_read_col),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_is_read_reply  (out_is_read_reply),
    .out_cell_count     (out_cell_count),
    .out_predicted_class(out_predicted_class),
    .out_expected_class (out_expected_class),
    .out_sample_counted (out_sample_counted),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_class_count    (cfg_class_count)
  );

  always #4 clk = ~clk;

  // Class count in force, with the register value clamped to the legal range.
  function automatic int unsigned active_classes();
    if (class_reg < CFG_BITS'(2)) return 2;
    if (int'(class_reg) > MAX_CLASSES) return MAX_CLASSES;
    return int'(class_reg);
  endfunction

  function automatic void restart_argmax();
    sample_pos = 0;
    top_pscore = SCORE_LO;
    top_escore = SCORE_LO;
    top_pclass = '0;
    top_eclass = '0;
  endfunction

  function automatic void wipe_counts();
    foreach (cell_counts[i]) cell_counts[i] = '0;
  endfunction

  // A write that changes the count in force empties the matrix and drops the sample.
  function automatic void apply_class_count(input logic [CFG_BITS-1:0] value);
    int unsigned was;
    was = active_classes();
    class_reg = value;
    if (active_classes() != was) begin
      wipe_counts();
      restart_argmax();
    end
  endfunction

  // Advances the matrix model by one transaction; returns 1 when a report comes of it.
  function automatic bit predict_matrix_step(input item_t it, output report_t rep);
    int unsigned                  n;
    int unsigned                  slot;
    logic signed [SCORE_BITS-1:0] ps;
    logic signed [SCORE_BITS-1:0] es;
    rep = '0;
    n = active_classes();
    ps = it.pscore;
    es = it.escore;
    case (it.kind)
      KIND_PAIR: begin
        if (sample_pos == 0 || ps > top_pscore) begin
          top_pscore = ps;
          top_pclass = IDX_BITS'(sample_pos);
        end
        if (sample_pos == 0 || es > top_escore) begin
          top_escore = es;
          top_eclass = IDX_BITS'(sample_pos);
        end
        if (sample_pos + 1 < n) begin
          sample_pos++;
          return 1'b0;
        end
        slot = int'(top_eclass) * MAX_CLASSES + int'(top_pclass);
        rep.counted = (top_escore >= 0);
        if (rep.counted && cell_counts[slot] != '1) cell_counts[slot]++;
        rep.count  = cell_counts[slot];
        rep.pclass = top_pclass;
        rep.eclass = top_eclass;
        restart_argmax();
        return 1'b1;
      end
      KIND_READ: begin
        rep.is_read = 1'b1;
        if (int'(it.row) < int'(n) && int'(it.col) < int'(n)) begin
          rep.count = cell_counts[int'(it.row) * MAX_CLASSES + int'(it.col)];
        end
        return 1'b1;
      end
      KIND_CLEAR: wipe_counts();
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned draw_gap(input bit calm, input int unsigned longest);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, longest);
  endfunction

  function automatic int unsigned pick_hot(input int unsigned n);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return n - 1;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  // Score shapes: anything, one clear winner, near-ties around zero, extremes, all negative.
  function automatic logic signed [SCORE_BITS-1:0] draw_score(input score_style_t style,
                                                              input bit hot);
    case (style)
      STYLE_ANY:   return SCORE_BITS'($urandom);
      STYLE_HOT:   return hot ? SCORE_BITS'(20000)
                              : SCORE_BITS'(int'($urandom_range(0, 39999)) - 20000);
      STYLE_TIGHT: return SCORE_BITS'(int'($urandom_range(0, 2)) - 1);
      STYLE_EDGE: begin
        case ($urandom_range(0, 3))
          0: return SCORE_LO;
          1: return SCORE_HI;
          2: return '1;
          default: return '0;
        endcase
      end
      default:     return SCORE_BITS'(-int'($urandom_range(1, 32768)));
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [COUNT_BITS-1:0] want,
                                      input logic [COUNT_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Offers one transaction, waits for it to be taken, then idles for a while.
  task automatic send_item(input item_t it, input bit has_fixed, input report_t fixed_rep);
    report_t     rep;
    int unsigned gap;
    in_valid           <= 1'b1;
    in_kind            <= it.kind;
    in_predicted_score <= it.pscore;
    in_expected_score  <= it.escore;
    in_read_row        <= it.row;
    in_read_col        <= it.col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_matrix_step(it, rep)) pending_reports.push_back(has_fixed ? fixed_rep : rep);
    gap = draw_gap(calm_in, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender off until every report is in, then lets the pipeline settle.
  task automatic wait_drained(input int unsigned pad);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (pad) @(posedge clk);
  endtask

  task automatic write_class_count(input logic [CFG_BITS-1:0] value);
    wait_drained(DRAIN_PAD);
    cfg_valid       <= 1'b1;
    cfg_class_count <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_class_count(value);
    cfg_valid <= 1'b0;
  endtask

  // Result side stalls.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= draw_gap(calm_out, 40);
    end
  end

  // Each result transaction is compared with the oldest outstanding report.
  always @(posedge clk) begin : check_reports
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("result with nothing outstanding: cell_count %0d", out_cell_count);
        failed = 1'b1;
      end else begin
        want = pending_reports.pop_front();
        check_field("is_read_reply", COUNT_BITS'(want.is_read), COUNT_BITS'(out_is_read_reply));
        check_field("cell_count", want.count, out_cell_count);
        check_field("predicted_class", COUNT_BITS'(want.pclass),
                    COUNT_BITS'(out_predicted_class));
        check_field("expected_class", COUNT_BITS'(want.eclass),
                    COUNT_BITS'(out_expected_class));
        check_field("sample_counted", COUNT_BITS'(want.counted),
                    COUNT_BITS'(out_sample_counted));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [CFG_BITS-1:0] phase_counts [N_PHASES];
    item_t               it;
    int unsigned         n;
    int unsigned         sent;
    int unsigned         r;
    int unsigned         hot_p;
    int unsigned         hot_e;
    bit                  paused;
    score_style_t        pstyle;
    score_style_t        estyle;

    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_kind            = KIND_PAIR;
    in_predicted_score = '0;
    in_expected_score  = '0;
    in_read_row        = '0;
    in_read_col        = '0;
    out_ready          = 1'b0;
    cfg_valid          = 1'b0;
    cfg_class_count    = '0;
    stall_left         = 0;
    cycles             = 0;
    failed             = 1'b0;
    calm_in            = 1'b0;
    calm_out           = 1'b0;
    class_reg          = CFG_BITS'(2);
    wipe_counts();
    restart_argmax();
    hot_p  = 0;
    hot_e  = 0;
    pstyle = STYLE_ANY;
    estyle = STYLE_ANY;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_STEPS[i]) begin
      send_item(DIRECTED_STEPS[i].item, DIRECTED_STEPS[i].fixed, DIRECTED_STEPS[i].want);
    end

    // Class counts per phase: a no-change write first, then both clamps and the extremes.
    phase_counts = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd17, 5'd2, 5'd9, 5'd0};
    phase_counts[N_PHASES-1] = CFG_BITS'($urandom_range(3, 15));

    for (int p = 0; p < int'(N_PHASES); p++) begin
      write_class_count(phase_counts[p]);
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      n        = active_classes();
      sent     = 0;
      paused   = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        if (!paused && sent == ITEMS_PER_PHASE / 2) begin
          wait_drained(0);
          paused = 1'b1;
        end
        // New score shapes and winning classes at the start of each sample.
        if (sample_pos == 0) begin
          pstyle = score_style_t'($urandom_range(0, 4));
          estyle = score_style_t'($urandom_range(0, 4));
          hot_p  = pick_hot(n);
          hot_e  = ($urandom_range(0, 1) == 0) ? hot_p : pick_hot(n);
        end
        it.pscore = SCORE_BITS'($urandom);
        it.escore = SCORE_BITS'($urandom);
        it.row    = IDX_BITS'($urandom);
        it.col    = IDX_BITS'($urandom);
        r = $urandom_range(0, 99);
        if (r < 74) begin
          it.kind   = KIND_PAIR;
          it.pscore = draw_score(pstyle, sample_pos == hot_p);
          it.escore = draw_score(estyle, sample_pos == hot_e);
        end else if (r < 93) begin
          it.kind = KIND_READ;
          if ($urandom_range(0, 4) != 0) begin
            it.row = IDX_BITS'($urandom_range(0, n - 1));
            it.col = IDX_BITS'($urandom_range(0, n - 1));
          end
        end else if (r < 96) begin
          it.kind = KIND_CLEAR;
        end else begin
          it.kind = KIND_UNUSED;
        end
        send_item(it, 1'b0, NO_REPORT);
        if (it.kind != KIND_UNUSED) sent++;
      end
    end

    wait_drained(DRAIN_PAD);
    if (!failed && pending_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
